>>> rtl/core/assert_macros.svh
// assert_macros.svh: concurrent assertion macros for the svpwm compare block
// depends on nothing; included by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock outside reset
`define FVS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// expression must never be true outside reset
`define FVS_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define FVS_ASSERT(lbl, clk, rstn, prop, msg)
`define FVS_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

>>> rtl/core/fvs_pkg.sv
// fvs_pkg: constants, widths and types shared by the svpwm compare pipeline
// no dependencies
package fvs_pkg;

    // field formats
    localparam int ANGLE_BITS = 16;
    localparam int VOLT_BITS  = 16;

    // quarter sine polynomial coefficients, q15
    localparam logic [15:0] SIN_A   = 16'd51472;
    localparam logic [14:0] SIN_B   = 15'd21024;
    localparam logic [11:0] SIN_C   = 12'd2320;
    localparam logic [15:0] Q15_ONE = 16'd32768;
    localparam logic [14:0] Q15_MAX = 15'h7fff;

    // sqrt(3)/2 in q15
    localparam logic signed [15:0] HALF_SQRT3_Q15 = 16'sd28378;

    // datapath widths
    localparam int PH_W  = 48;  // phase voltage, scale 2^30
    localparam int MX_W  = 51;  // injected phase voltage, scale 2^31
    localparam int M_W   = 35;  // injected voltage, scale 2^15
    localparam int P_W   = 52;  // m * period
    localparam int SUM_W = 53;  // numerator before the 2^15 shift
    localparam int NUM_W = 38;  // numerator over 2^16
    localparam int QUO_W = 16;  // compare quotient

    // pipeline depths
    localparam int SC_STAGES  = 5;
    localparam int PC_STAGES  = 6;
    localparam int DIV_STAGES = 8;
    localparam int CMP_STAGES = DIV_STAGES + 3;

    // configuration register indexes
    localparam int          CFG_IDX_W       = 2;
    localparam logic [1:0]  REG_BUS_VOLTAGE = 2'd0;
    localparam logic [1:0]  REG_PWM_PERIOD  = 2'd1;

    localparam logic [14:0] BUS_RESET    = 15'd16384;
    localparam logic [15:0] PERIOD_RESET = 16'd4096;

    typedef logic signed [M_W-1:0] t_mval;

endpackage

>>> rtl/core/fvs_sincos.sv
// fvs_sincos: angle decode and quarter sine polynomial, five register stages
// depends on fvs_pkg
module fvs_sincos (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_ready,
    output logic               o_valid,
    input  logic signed [15:0] i_volt_direct,
    input  logic signed [15:0] i_volt_quadrature,
    input  logic [15:0]        i_rotor_angle,
    output logic signed [15:0] o_sin,
    output logic signed [15:0] o_cos,
    output logic signed [15:0] o_volt_direct,
    output logic signed [15:0] o_volt_quadrature
);
    import fvs_pkg::*;

    logic [SC_STAGES-1:0] r_v;
    logic [SC_STAGES-1:0] n_en;

    logic [ANGLE_BITS-1:0]  n_ang;
    logic [ANGLE_BITS+12:0] n_zwide;
    logic [14:0]            n_z;
    logic signed [15:0]     n_vd;
    logic signed [15:0]     n_vq;

    logic [1:0]         r_quad [SC_STAGES-1];
    logic signed [15:0] r_vd   [SC_STAGES];
    logic signed [15:0] r_vq   [SC_STAGES];

    logic [15:0] r_zz0 [2];
    logic [15:0] r_zz1 [2];
    logic [15:0] r_z2_1 [2];
    logic [15:0] r_zz2 [2];
    logic [15:0] r_z2_2 [2];
    logic [14:0] r_t1_2 [2];
    logic [15:0] r_zz3 [2];
    logic [15:0] r_t2_3 [2];
    logic signed [15:0] r_sin;
    logic signed [15:0] r_cos;

    logic [31:0] n_p1 [2];
    logic [26:0] n_p2 [2];
    logic [29:0] n_p3 [2];
    logic [30:0] n_p4 [2];
    logic [14:0] n_mag [2];
    logic [14:0] n_sin_mag;
    logic [14:0] n_cos_mag;

    // stall chain: a stage moves when it is empty or the next one moves
    always_comb begin
        n_en[SC_STAGES-1] = !r_v[SC_STAGES-1] || i_ready;
        for (int k = SC_STAGES - 2; k >= 0; k--) begin
            n_en[k] = !r_v[k] || n_en[k+1];
        end
    end

    assign o_ready = n_en[0];
    assign o_valid = r_v[SC_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (n_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < SC_STAGES; k++) begin
                if (n_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // angle reduced to the turn
    if (ANGLE_BITS >= 16) begin : g_ang_wide
        assign n_ang = ANGLE_BITS'(i_rotor_angle);
    end else begin : g_ang_narrow
        assign n_ang = i_rotor_angle[ANGLE_BITS-1:0];
    end

    // voltage commands read at the configured width
    if (VOLT_BITS < 16) begin : g_volt_narrow
        assign n_vd = 16'(signed'(i_volt_direct[VOLT_BITS-1:0]));
        assign n_vq = 16'(signed'(i_volt_quadrature[VOLT_BITS-1:0]));
    end else begin : g_volt_full
        assign n_vd = i_volt_direct;
        assign n_vq = i_volt_quadrature;
    end

    // quadrant fraction scaled to q15
    assign n_zwide = {n_ang[ANGLE_BITS-3:0], 15'b0} >> (ANGLE_BITS - 2);
    assign n_z     = n_zwide[14:0];

    // polynomial products, lane 0 on z and lane 1 on the complement
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_p1[l] = 32'(r_zz0[l]) * 32'(r_zz0[l]);
            n_p2[l] = 27'(SIN_C) * 27'(r_z2_1[l]);
            n_p3[l] = 30'(r_t1_2[l]) * 30'(r_z2_2[l]);
            n_p4[l] = 31'(r_t2_3[l]) * 31'(r_zz3[l]);
            n_mag[l] = n_p4[l][30] ? Q15_MAX : n_p4[l][29:15];
        end
    end

    // odd quadrants mirror the quarter wave
    assign n_sin_mag = r_quad[SC_STAGES-2][0] ? n_mag[1] : n_mag[0];
    assign n_cos_mag = r_quad[SC_STAGES-2][0] ? n_mag[0] : n_mag[1];

    always_ff @(posedge i_clk) begin
        // decode
        if (n_en[0]) begin
            r_quad[0] <= n_ang[ANGLE_BITS-1 -: 2];
            r_vd[0]   <= n_vd;
            r_vq[0]   <= n_vq;
            r_zz0[0]  <= {1'b0, n_z};
            r_zz0[1]  <= Q15_ONE - {1'b0, n_z};
        end
        // z squared
        if (n_en[1]) begin
            for (int l = 0; l < 2; l++) begin
                r_z2_1[l] <= n_p1[l][30:15];
                r_zz1[l]  <= r_zz0[l];
            end
        end
        // inner term
        if (n_en[2]) begin
            for (int l = 0; l < 2; l++) begin
                r_t1_2[l] <= SIN_B - {3'b0, n_p2[l][26:15]};
                r_z2_2[l] <= r_z2_1[l];
                r_zz2[l]  <= r_zz1[l];
            end
        end
        // middle term
        if (n_en[3]) begin
            for (int l = 0; l < 2; l++) begin
                r_t2_3[l] <= SIN_A - {1'b0, n_p3[l][29:15]};
                r_zz3[l]  <= r_zz2[l];
            end
        end
        // final product, clamp and sign
        if (n_en[4]) begin
            r_sin <= r_quad[3][1] ? -signed'({1'b0, n_sin_mag})
                                  : signed'({1'b0, n_sin_mag});
            r_cos <= (r_quad[3][1] ^ r_quad[3][0]) ? -signed'({1'b0, n_cos_mag})
                                                   : signed'({1'b0, n_cos_mag});
        end
        for (int k = 1; k < SC_STAGES; k++) begin
            if (n_en[k]) begin
                r_vd[k] <= r_vd[k-1];
                r_vq[k] <= r_vq[k-1];
            end
        end
        for (int k = 1; k < SC_STAGES - 1; k++) begin
            if (n_en[k]) begin
                r_quad[k] <= r_quad[k-1];
            end
        end
    end

    assign o_sin             = r_sin;
    assign o_cos             = r_cos;
    assign o_volt_direct     = r_vd[SC_STAGES-1];
    assign o_volt_quadrature = r_vq[SC_STAGES-1];

endmodule

>>> rtl/core/fvs_park_clarke.sv
// fvs_park_clarke: inverse park, inverse clarke and min-max injection
// depends on fvs_pkg
module fvs_park_clarke (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_ready,
    output logic               o_valid,
    input  logic signed [15:0] i_sin,
    input  logic signed [15:0] i_cos,
    input  logic signed [15:0] i_volt_direct,
    input  logic signed [15:0] i_volt_quadrature,
    output fvs_pkg::t_mval     o_m [3]
);
    import fvs_pkg::*;

    logic [PC_STAGES-1:0] r_v;
    logic [PC_STAGES-1:0] n_en;

    logic signed [31:0]     r_p_dc, r_p_qs, r_p_ds, r_p_qc;
    logic signed [31:0]     r_alpha, r_beta;
    logic signed [PH_W-1:0] r_ph0, r_a14, r_pb;
    logic signed [PH_W-1:0] r_ph3 [3];
    logic signed [PH_W-1:0] r_ph4 [3];
    logic signed [PH_W-1:0] r_max, r_min;
    t_mval                  r_m [3];

    logic signed [PH_W-1:0] n_max, n_min;
    logic signed [MX_W-1:0] n_mx [3];

    // stall chain
    always_comb begin
        n_en[PC_STAGES-1] = !r_v[PC_STAGES-1] || i_ready;
        for (int k = PC_STAGES - 2; k >= 0; k--) begin
            n_en[k] = !r_v[k] || n_en[k+1];
        end
    end

    assign o_ready = n_en[0];
    assign o_valid = r_v[PC_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (n_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < PC_STAGES; k++) begin
                if (n_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // largest and smallest phase
    always_comb begin
        n_max = r_ph3[0];
        n_min = r_ph3[0];
        for (int l = 1; l < 3; l++) begin
            if (r_ph3[l] > n_max) begin
                n_max = r_ph3[l];
            end
            if (r_ph3[l] < n_min) begin
                n_min = r_ph3[l];
            end
        end
    end

    // zero-sequence injection
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_mx[l] = (MX_W'(r_ph4[l]) <<< 1) - MX_W'(r_max) - MX_W'(r_min);
        end
    end

    always_ff @(posedge i_clk) begin
        // park products
        if (n_en[0]) begin
            r_p_dc <= i_volt_direct * i_cos;
            r_p_qs <= i_volt_quadrature * i_sin;
            r_p_ds <= i_volt_direct * i_sin;
            r_p_qc <= i_volt_quadrature * i_cos;
        end
        // alpha and beta
        if (n_en[1]) begin
            r_alpha <= r_p_dc - r_p_qs;
            r_beta  <= r_p_ds + r_p_qc;
        end
        // clarke terms
        if (n_en[2]) begin
            r_ph0 <= PH_W'(r_alpha) <<< 15;
            r_a14 <= PH_W'(r_alpha) <<< 14;
            r_pb  <= r_beta * HALF_SQRT3_Q15;
        end
        // phase voltages
        if (n_en[3]) begin
            r_ph3[0] <= r_ph0;
            r_ph3[1] <= r_pb - r_a14;
            r_ph3[2] <= -r_a14 - r_pb;
        end
        if (n_en[4]) begin
            r_ph4 <= r_ph3;
            r_max <= n_max;
            r_min <= n_min;
        end
        // back to scale 2^15, floored
        if (n_en[5]) begin
            for (int l = 0; l < 3; l++) begin
                r_m[l] <= n_mx[l][MX_W-1:MX_W-M_W];
            end
        end
    end

    assign o_m = r_m;

endmodule

>>> rtl/core/fvs_compare.sv
// fvs_compare: scaling to timer counts, radix-4 restoring divide by bus voltage, clamp
// depends on fvs_pkg
module fvs_compare (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic           i_ready,
    output logic           o_valid,
    input  fvs_pkg::t_mval i_m [3],
    input  logic [15:0]    i_pwm_period,
    input  logic [14:0]    i_bus_voltage,
    input  logic [31:0]    i_bus_period,
    output logic [15:0]    o_compare [3],
    output logic           o_overmodulated
);
    import fvs_pkg::*;

    logic [CMP_STAGES-1:0] r_v;
    logic [CMP_STAGES-1:0] n_en;

    logic signed [P_W-1:0]   r_prod [3];
    logic signed [SUM_W-1:0] n_sum [3];
    logic signed [NUM_W-1:0] n_num [3];
    logic                    n_neg [3];
    logic                    n_over [3];

    // index 0 is the classified numerator, then one per divider stage
    logic [31:0]      r_rem  [DIV_STAGES+1][3];
    logic [QUO_W-1:0] r_q    [DIV_STAGES+1][3];
    logic             r_neg  [DIV_STAGES+1][3];
    logic             r_over [DIV_STAGES+1][3];

    logic [31:0]      n_rem [DIV_STAGES][3];
    logic [QUO_W-1:0] n_q   [DIV_STAGES][3];
    logic [31:0]      n_dv;

    logic [15:0] r_cmp [3];
    logic        r_flag;
    logic [15:0] n_cmp [3];
    logic        n_flag;

    // stall chain
    always_comb begin
        n_en[CMP_STAGES-1] = !r_v[CMP_STAGES-1] || i_ready;
        for (int k = CMP_STAGES - 2; k >= 0; k--) begin
            n_en[k] = !r_v[k] || n_en[k+1];
        end
    end

    assign o_ready = n_en[0];
    assign o_valid = r_v[CMP_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (n_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < CMP_STAGES; k++) begin
                if (n_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // numerator over 2^16 and range check against (period + 1) * bus
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_sum[l]  = SUM_W'(r_prod[l]) + signed'({7'b0, i_bus_period, 14'b0});
            n_num[l]  = n_sum[l][SUM_W-1:15];
            n_neg[l]  = n_num[l][NUM_W-1];
            n_over[l] = !n_neg[l] && (n_num[l][NUM_W-2:0] >= (NUM_W-1)'(i_bus_period));
        end
    end

    // two quotient bits per stage
    always_comb begin
        n_dv = '0;
        for (int s = 0; s < DIV_STAGES; s++) begin
            for (int l = 0; l < 3; l++) begin
                n_rem[s][l] = r_rem[s][l];
                n_q[s][l]   = r_q[s][l];
                for (int b = 0; b < 2; b++) begin
                    n_dv = 32'(i_bus_voltage) << (QUO_W - 1 - 2 * s - b);
                    if (n_rem[s][l] >= n_dv) begin
                        n_rem[s][l] = n_rem[s][l] - n_dv;
                        n_q[s][l][QUO_W-1-2*s-b] = 1'b1;
                    end
                end
            end
        end
    end

    // clamp to 0..period
    always_comb begin
        n_flag = 1'b0;
        for (int l = 0; l < 3; l++) begin
            if (r_neg[DIV_STAGES][l]) begin
                n_cmp[l] = '0;
                n_flag   = 1'b1;
            end else if (r_over[DIV_STAGES][l]) begin
                n_cmp[l] = i_pwm_period;
                n_flag   = 1'b1;
            end else begin
                n_cmp[l] = r_q[DIV_STAGES][l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en[0]) begin
            for (int l = 0; l < 3; l++) begin
                r_prod[l] <= i_m[l] * signed'({1'b0, i_pwm_period});
            end
        end
        if (n_en[1]) begin
            for (int l = 0; l < 3; l++) begin
                r_rem[0][l]  <= n_num[l][31:0];
                r_q[0][l]    <= '0;
                r_neg[0][l]  <= n_neg[l];
                r_over[0][l] <= n_over[l];
            end
        end
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (n_en[s+2]) begin
                for (int l = 0; l < 3; l++) begin
                    r_rem[s+1][l]  <= n_rem[s][l];
                    r_q[s+1][l]    <= n_q[s][l];
                    r_neg[s+1][l]  <= r_neg[s][l];
                    r_over[s+1][l] <= r_over[s][l];
                end
            end
        end
        if (n_en[CMP_STAGES-1]) begin
            r_cmp  <= n_cmp;
            r_flag <= n_flag;
        end
    end

    assign o_compare       = r_cmp;
    assign o_overmodulated = r_flag;

endmodule

>>> rtl/core/foc_voltage_to_svpwm_compare.sv
// foc_voltage_to_svpwm_compare: top level, configuration registers and stream ports
// depends on fvs_pkg, fvs_sincos, fvs_park_clarke, fvs_compare, assert_macros.svh
`include "assert_macros.svh"

// Turns a d/q voltage command and an electrical angle into three PWM compare
// values with min-max zero-sequence injection. One transfer is taken per clock
// unless a stalled output has backed the pipeline up, and each result passes
// through 5 stages of sine polynomial, 6 of park/clarke/injection and 11 of
// scaling, an 8-stage radix-4 divide by the bus voltage and the clamp. Every
// stage holds its own valid bit, so a stalled output only backs up as far as
// the pipeline is full. Register 0 is the bus voltage, register 1 the period;
// write them only while no result is pending; the next input transfer may
// follow the write at once.
module foc_voltage_to_svpwm_compare (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [15:0] volt_direct, [31:16] volt_quadrature, [47:32] rotor_angle
    input  logic [47:0] i_s_axis_tdata,
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [15:0] compare_phase_u, [31:16] compare_phase_v, [47:32] compare_phase_w
    output logic [47:0] o_m_axis_tdata,
    // [0] overmodulated
    output logic [0:0]  o_m_axis_tuser,
    // configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [fvs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [15:0]                    i_cfg_data
);
    import fvs_pkg::*;

    logic [14:0] r_bus_voltage;
    logic [15:0] r_pwm_period;
    logic [31:0] r_bus_period;
    logic [14:0] n_bus_eff;

    logic               sc_valid, sc_ready;
    logic signed [15:0] sc_sin, sc_cos, sc_vd, sc_vq;
    logic               pc_valid, pc_ready;
    t_mval              pc_m [3];
    logic [15:0]        cmp [3];
    logic               cmp_flag;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus_voltage <= BUS_RESET;
            r_pwm_period  <= PERIOD_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_BUS_VOLTAGE: r_bus_voltage <= i_cfg_data[14:0];
                REG_PWM_PERIOD:  r_pwm_period  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // zero bus voltage counts as one; (period + 1) * bus kept registered
    assign n_bus_eff = (r_bus_voltage == '0) ? 15'd1 : r_bus_voltage;

    always_ff @(posedge i_clk) begin
        r_bus_period <= 32'(n_bus_eff) * (32'(r_pwm_period) + 32'd1);
    end

    fvs_sincos u_sincos (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_s_axis_tvalid),
        .o_ready           (o_s_axis_tready),
        .i_ready           (pc_ready),
        .o_valid           (sc_valid),
        .i_volt_direct     (i_s_axis_tdata[15:0]),
        .i_volt_quadrature (i_s_axis_tdata[31:16]),
        .i_rotor_angle     (i_s_axis_tdata[47:32]),
        .o_sin             (sc_sin),
        .o_cos             (sc_cos),
        .o_volt_direct     (sc_vd),
        .o_volt_quadrature (sc_vq)
    );

    fvs_park_clarke u_park_clarke (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (sc_valid),
        .o_ready           (pc_ready),
        .i_ready           (sc_ready),
        .o_valid           (pc_valid),
        .i_sin             (sc_sin),
        .i_cos             (sc_cos),
        .i_volt_direct     (sc_vd),
        .i_volt_quadrature (sc_vq),
        .o_m               (pc_m)
    );

    fvs_compare u_compare (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (pc_valid),
        .o_ready         (sc_ready),
        .i_ready         (i_m_axis_tready),
        .o_valid         (o_m_axis_tvalid),
        .i_m             (pc_m),
        .i_pwm_period    (r_pwm_period),
        .i_bus_voltage   (n_bus_eff),
        .i_bus_period    (r_bus_period),
        .o_compare       (cmp),
        .o_overmodulated (cmp_flag)
    );

    assign o_m_axis_tdata = {cmp[2], cmp[1], cmp[0]};
    assign o_m_axis_tuser = cmp_flag;

    // compares never leave the period range
    `FVS_ASSERT(a_cmp_in_range, i_clk, i_rst_n,
        o_m_axis_tvalid |-> (o_m_axis_tdata[15:0] <= r_pwm_period) &&
        (o_m_axis_tdata[31:16] <= r_pwm_period) && (o_m_axis_tdata[47:32] <= r_pwm_period),
        "compare beyond period")

    // zero period gives zero compares and no flag
    `FVS_ASSERT(a_zero_period, i_clk, i_rst_n,
        o_m_axis_tvalid && (r_pwm_period == 16'd0) |->
        (o_m_axis_tdata == 48'd0) && !o_m_axis_tuser[0],
        "zero period result")

    // an empty output stage frees the whole stall chain
    `FVS_NEVER(a_ready_free, i_clk, i_rst_n, !o_m_axis_tvalid && !o_s_axis_tready,
        "input blocked with output empty")

endmodule

>>> sim/foc_voltage_to_svpwm_compare_tb.sv
// foc_voltage_to_svpwm_compare_tb: self-checking bench for the svpwm compare block
// depends on fvs_pkg and foc_voltage_to_svpwm_compare; predicts each compare triple
// from the d/q command, angle and the current bus voltage and period settings
`timescale 1ns / 100ps

module foc_voltage_to_svpwm_compare_tb;
    import fvs_pkg::*;

    typedef struct packed {
        logic        overmod;
        logic [15:0] cmp_w;
        logic [15:0] cmp_v;
        logic [15:0] cmp_u;
    } t_compare;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [47:0] i_s_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [47:0] o_m_axis_tdata;
    logic [0:0]  o_m_axis_tuser;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [15:0] i_cfg_data;

    // predictor copy of the configuration
    logic [14:0] bus_volt_set;
    logic [15:0] period_set;

    t_compare compare_queue[$];
    int  send_idle_pct;
    int  recv_idle_pct;
    int  errors;
    int  stall_count;
    bit  running;

    foc_voltage_to_svpwm_compare dut (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // q15 quarter sine polynomial
    function automatic longint quarter_sine(longint z);
        longint z2;
        longint t;
        z2 = (z * z) >>> 15;
        t = (2320 * z2) >>> 15;
        t = 21024 - t;
        t = (t * z2) >>> 15;
        t = 51472 - t;
        t = (t * z) >>> 15;
        return (t > 32767) ? 32767 : t;
    endfunction

    function automatic longint sine_q15(logic [1:0] quad, longint z);
        longint mag;
        mag = quad[0] ? quarter_sine(32768 - z) : quarter_sine(z);
        return quad[1] ? -mag : mag;
    endfunction

    function automatic longint div_floor(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    // expected compares for one command at the current settings
    function automatic t_compare calc_compares(logic [15:0] vd_raw, logic [15:0] vq_raw,
                                               logic [15:0] ang);
        longint vd, vq, z, sn, cs, alpha, beta, mx, mn, u, t, den, m, num, c;
        longint ph[3];
        logic [15:0] cmp[3];
        t_compare res;
        vd = longint'($signed(vd_raw));
        vq = longint'($signed(vq_raw));
        z  = longint'(ang[13:0]) * 2;
        sn = sine_q15(ang[15:14], z);
        cs = sine_q15(ang[15:14] + 2'd1, z);
        alpha = vd * cs - vq * sn;
        beta  = vd * sn + vq * cs;
        ph[0] = alpha * 32768;
        ph[1] = -alpha * 16384 + beta * 28378;
        ph[2] = -alpha * 16384 - beta * 28378;
        mx = ph[0];
        mn = ph[0];
        for (int i = 1; i < 3; i++) begin
            if (ph[i] > mx) mx = ph[i];
            if (ph[i] < mn) mn = ph[i];
        end
        u = (bus_volt_set == 0) ? 1 : longint'(bus_volt_set);
        t = longint'(period_set);
        den = u * 65536;
        res.overmod = 1'b0;
        for (int i = 0; i < 3; i++) begin
            m = (2 * ph[i] - mx - mn) >>> 16;
            num = 2 * m * t + u * t * 32768 + u * 32768;
            c = div_floor(num, den);
            if (c < 0) begin
                c = 0;
                res.overmod = 1'b1;
            end else if (c > t) begin
                c = t;
                res.overmod = 1'b1;
            end
            cmp[i] = c[15:0];
        end
        res.cmp_u = cmp[0];
        res.cmp_v = cmp[1];
        res.cmp_w = cmp[2];
        return res;
    endfunction

    // one command transfer, valid stays high for a back-to-back item
    task automatic send_command(logic [15:0] vd, logic [15:0] vq, logic [15:0] ang);
        if ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {ang, vq, vd};
        do @(posedge i_clk); while (!o_s_axis_tready);
        compare_queue.push_back(calc_compares(vd, vq, ang));
    endtask

    // let every pending result come out, then settle
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (compare_queue.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_BUS_VOLTAGE)
            bus_volt_set = val[14:0];
        else if (idx == REG_PWM_PERIOD)
            period_set = val;
    endtask

    task automatic apply_settings(logic [15:0] bus, logic [15:0] period);
        drain_results();
        write_reg(REG_BUS_VOLTAGE, bus);
        write_reg(REG_PWM_PERIOD, period);
        i_cfg_valid <= 1'b0;
        repeat (3) @(posedge i_clk);
    endtask

    // field extremes and quadrant edges at reset settings, then the special cases
    task automatic test_directed();
        logic [15:0] angs[6] = '{16'h0000, 16'h3fff, 16'h4000, 16'h8000, 16'hc000, 16'hffff};
        send_command(16'h0000, 16'h0000, 16'h0000);
        foreach (angs[i])
            send_command(16'h7fff, 16'h8000, angs[i]);
        send_command(16'h8000, 16'h7fff, 16'h2000);
        send_command(16'h1000, 16'h0800, 16'h1234);
        send_command(16'hffff, 16'h0001, 16'h5555);
        // overmodulation with a tiny bus voltage
        apply_settings(16'd1, 16'd65535);
        send_command(16'h0100, 16'h0000, 16'h0000);
        send_command(16'h8000, 16'h8000, 16'hffff);
        // zero bus voltage counts as one, upper data bit dropped
        apply_settings(16'h8000, 16'd1000);
        send_command(16'h0003, 16'hfffd, 16'h1000);
        send_command(16'h0000, 16'h0000, 16'h7000);
        // zero period
        apply_settings(16'hffff, 16'd0);
        send_command(16'h7fff, 16'h7fff, 16'h9abc);
        send_command(16'h0000, 16'h0000, 16'h0000);
        // unknown register indexes change nothing
        drain_results();
        write_reg(2'd2, 16'hffff);
        write_reg(2'd3, 16'h0000);
        i_cfg_valid <= 1'b0;
        repeat (3) @(posedge i_clk);
        send_command(16'h2000, 16'he000, 16'h4321);
    endtask

    // random commands under a sweep of settings, extremes included
    task automatic test_random(int items);
        logic [15:0] bus, period, vd, vq;
        int lim;
        for (int blk = 0; blk < 5; blk++) begin
            case (blk)
                0: begin bus = 16'd32767; period = 16'd65535; end
                1: begin bus = 16'd1;     period = 16'd1;     end
                2: begin bus = 16'd16384; period = 16'd4096;  end
                default: begin
                    bus = 16'($urandom_range(65535));
                    period = 16'($urandom_range(65535));
                end
            endcase
            apply_settings(bus, period);
            lim = (bus_volt_set == 0) ? 1 : int'(bus_volt_set);
            for (int n = 0; n < items / 5; n++) begin
                if ($urandom_range(3) == 0) begin
                    vd = 16'($urandom_range(65535));
                    vq = 16'($urandom_range(65535));
                end else begin
                    // mostly inside the linear range for this bus voltage
                    vd = 16'($urandom_range(2 * lim) - lim);
                    vq = 16'($urandom_range(2 * lim) - lim);
                end
                send_command(vd, vq, 16'($urandom_range(65535)));
            end
        end
    endtask

    // receiver backpressure
    always @(posedge i_clk)
        i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (compare_queue.size() == 0) begin
                $display("%0t: unexpected result tdata=%h tuser=%b", $time,
                         o_m_axis_tdata, o_m_axis_tuser);
                errors++;
            end else begin
                t_compare exp_c;
                exp_c = compare_queue.pop_front();
                if (o_m_axis_tdata[15:0] !== exp_c.cmp_u) begin
                    $display("%0t: phase u expected %0d got %0d", $time, exp_c.cmp_u,
                             o_m_axis_tdata[15:0]);
                    errors++;
                end
                if (o_m_axis_tdata[31:16] !== exp_c.cmp_v) begin
                    $display("%0t: phase v expected %0d got %0d", $time, exp_c.cmp_v,
                             o_m_axis_tdata[31:16]);
                    errors++;
                end
                if (o_m_axis_tdata[47:32] !== exp_c.cmp_w) begin
                    $display("%0t: phase w expected %0d got %0d", $time, exp_c.cmp_w,
                             o_m_axis_tdata[47:32]);
                    errors++;
                end
                if (o_m_axis_tuser[0] !== exp_c.overmod) begin
                    $display("%0t: overmodulated expected %b got %b", $time,
                             exp_c.overmod, o_m_axis_tuser[0]);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!running || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready) || (i_cfg_valid && o_cfg_ready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= 5000) begin
            $display("foc_voltage_to_svpwm_compare verification failed");
            $finish;
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= REG_BUS_VOLTAGE;
        i_cfg_data      <= '0;
        i_m_axis_tready <= 1'b0;
        bus_volt_set  = BUS_RESET;
        period_set    = PERIOD_RESET;
        errors        = 0;
        stall_count   = 0;
        running       = 1'b0;
        send_idle_pct = 16;
        recv_idle_pct = 88;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        running = 1'b1;

        test_directed();
        test_random(400);
        send_idle_pct = 88;
        recv_idle_pct = 16;
        test_random(400);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(430);

        drain_results();
        repeat (30) @(posedge i_clk);
        if (errors == 0)
            $display("foc_voltage_to_svpwm_compare verification clean");
        else
            $display("foc_voltage_to_svpwm_compare verification failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/fvs_pkg.sv
rtl/core/fvs_sincos.sv
rtl/core/fvs_park_clarke.sv
rtl/core/fvs_compare.sv
rtl/core/foc_voltage_to_svpwm_compare.sv
sim/foc_voltage_to_svpwm_compare_tb.sv
